// ===== hw/rtl/lcgrg_pkg.sv =====
package lcgrg_pkg;

    localparam int WORD_W = 32;
    localparam int STATE_W = 64;
    localparam int DIGIT_W = 2;
    localparam int MUL_STEPS = STATE_W / DIGIT_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int DIV_STEPS = WORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [STATE_W-1:0] LCG_MULT = 64'h5851_F42D_4C95_7F2D;

    typedef enum logic [1:0] {
        ACT_SEED,
        ACT_RANGE,
        ACT_UNIFORM,
        ACT_NONE
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } t_state;

    // Multiple of the multiplier selected by one radix-4 digit of the operand.
    function automatic logic [STATE_W-1:0] digit_multiple(input logic [DIGIT_W-1:0] digit);
        logic [STATE_W-1:0] res;
        case (digit)
            2'd0: res = '0;
            2'd1: res = LCG_MULT;
            2'd2: res = LCG_MULT << 1;
            2'd3: res = LCG_MULT + (LCG_MULT << 1);
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

// ===== hw/rtl/lcg_random_range_generator.sv =====
// A range or uniform request runs through three steps after acceptance:
// the radix-4 serial multiply of the state, the bit-serial remainder,
// and loading the output register. A seed request skips the remainder, an unused action skips both.
// One request is in work at a time; a new one is taken as soon as the previous result
// sits in the output register; that load waits while a stalled result is still held.
// Synchronous active-low reset clears the generator state to zero and empties the output.
module lcg_random_range_generator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_action,
    input  logic [lcgrg_pkg::WORD_W-1:0] i_seed_value,
    input  logic [lcgrg_pkg::WORD_W-1:0] i_range_size,
    input  logic [lcgrg_pkg::WORD_W-1:0] i_low_bound,
    input  logic [lcgrg_pkg::WORD_W-1:0] i_high_bound,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [lcgrg_pkg::WORD_W-1:0] o_value
);
    import lcgrg_pkg::*;

    t_state             r_state;
    t_state             n_state;
    t_action            r_action;
    logic [STATE_W-1:0] r_lcg;
    logic [WORD_W-1:0]  r_divisor;
    logic [WORD_W-1:0]  r_offset;
    logic [WORD_W-1:0]  r_result;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_value;

    logic               w_accept;
    logic               w_mul_start;
    logic               w_mul_done;
    logic [STATE_W-1:0] w_product;
    logic [STATE_W-1:0] w_operand;
    logic               w_div_start;
    logic               w_div_done;
    logic [WORD_W-1:0]  w_remainder;
    logic               w_out_free;
    logic               w_load_out;
    logic               w_save_state;
    logic               w_save_result;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_operand  = (i_action == ACT_SEED) ? {{(STATE_W - WORD_W){1'b0}}, i_seed_value}
                                               : r_lcg;

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        w_mul_start   = 1'b0;
        w_div_start   = 1'b0;
        w_load_out    = 1'b0;
        w_save_state  = 1'b0;
        w_save_result = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_action == ACT_NONE) begin
                        n_state = ST_FIN;
                    end else begin
                        w_mul_start = 1'b1;
                        n_state     = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (w_mul_done) begin
                    w_save_state = 1'b1;
                    if (r_action == ACT_SEED) begin
                        n_state = ST_FIN;
                    end else begin
                        w_div_start = 1'b1;
                        n_state     = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    w_save_result = 1'b1;
                    n_state       = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_lcg       <= '0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_save_state) begin
                r_lcg <= w_product;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= t_action'(i_action);
            r_result <= '0;
            if (i_action == ACT_RANGE) begin
                r_divisor <= i_range_size;
                r_offset  <= '0;
            end else begin
                r_divisor <= i_high_bound - i_low_bound + WORD_W'(1);
                r_offset  <= i_low_bound;
            end
        end
        if (w_save_result) begin
            r_result <= w_remainder + r_offset;
        end
        if (w_load_out) begin
            r_value <= r_result;
        end
    end

    lcgrg_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_operand (w_operand),
        .i_add_one (i_action != ACT_SEED),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

    lcgrg_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_product[STATE_W-1 -: WORD_W]),
        .i_divisor   (r_divisor),
        .o_done      (w_div_done),
        .o_remainder (w_remainder)
    );

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;

endmodule

// ===== hw/rtl/lcgrg_mul.sv =====
module lcgrg_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lcgrg_pkg::STATE_W-1:0] i_operand,
    input  logic                          i_add_one,
    output logic                          o_done,
    output logic [lcgrg_pkg::STATE_W-1:0] o_product
);
    import lcgrg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_count;
    logic [STATE_W-1:0]   r_digits;
    logic [STATE_W-1:0]   r_acc;
    logic                 r_add_one;
    logic [STATE_W-1:0]   n_acc;
    logic                 w_last;

    // The operand is consumed most significant digit first, so the
    // multiplier multiple is added to the accumulator shifted by one digit.
    assign w_last = (r_count == MUL_CNT_W'(MUL_STEPS - 1));
    assign n_acc  = (r_acc << DIGIT_W) + digit_multiple(r_digits[STATE_W-1 -: DIGIT_W])
                    + STATE_W'(r_add_one && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= r_count + MUL_CNT_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_digits  <= i_operand;
            r_acc     <= '0;
            r_add_one <= i_add_one;
        end else if (r_busy) begin
            r_digits <= r_digits << DIGIT_W;
            r_acc    <= n_acc;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// ===== hw/rtl/lcgrg_div.sv =====
module lcgrg_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lcgrg_pkg::WORD_W-1:0] i_dividend,
    input  logic [lcgrg_pkg::WORD_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [lcgrg_pkg::WORD_W-1:0] o_remainder
);
    import lcgrg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_count;
    logic [WORD_W-1:0]    r_rem;
    logic [WORD_W-1:0]    r_bits;
    logic [WORD_W-1:0]    r_divisor;
    logic [WORD_W:0]      w_trial;
    logic [WORD_W:0]      w_diff;
    logic                 w_last;

    // Restoring division, one dividend bit per cycle. A zero divisor never
    // subtracts anything, so the remainder then equals the dividend.
    assign w_trial = {r_rem, r_bits[WORD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_divisor};
    assign w_last  = (r_count == DIV_CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= r_count + DIV_CNT_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_bits    <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_bits <= r_bits << 1;
            if (!w_diff[WORD_W]) begin
                r_rem <= w_diff[WORD_W-1:0];
            end else begin
                r_rem <= w_trial[WORD_W-1:0];
            end
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

// ===== hw/rtl/lcgrg_chk.sv =====
module lcgrg_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic [1:0]                   i_action,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [lcgrg_pkg::WORD_W-1:0] o_value
);
    import lcgrg_pkg::*;

    logic w_in_acc;
    logic w_out_stall;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_stall = o_out_valid && !i_out_ready;

    // Only one request is in work, so the input closes right after an acceptance.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("input stayed ready after a request was accepted");

    // A fresh result only appears while no new request can be taken.
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without a request in work");

    // A request that carries an unused action code finishes quickly with a zero value.
    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_action == ACT_NONE && !o_out_valid) |=> ##1 (o_out_valid && o_value == '0))
        else $error("unused action did not return zero");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_stall |=> (o_out_valid && $stable(o_value)))
        else $error("stalled result changed");

endmodule

bind lcg_random_range_generator lcgrg_chk u_lcgrg_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_action    (i_action),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_value     (o_value)
);
